>>> rtl/pgf_pkg.sv
// Shared types and constants for the pair gravity force block.
// No dependencies; every other file in rtl imports this package.
package pgf_pkg;

   // Defaults for the top-level parameters
   localparam int PGF_POS_FRAC_BITS = 8;
   localparam int PGF_CELL_BITS     = 16;

   // Fixed field widths
   localparam int POS_W   = 20;
   localparam int CELL_W  = 16;
   localparam int G_W     = 24;
   localparam int OUT_W   = 32;
   localparam int MAG_W   = POS_W;
   localparam int SQR_W   = 2 * MAG_W;
   localparam int SQ_W    = SQR_W + 1;
   localparam int ROOT_W  = 21;
   localparam int PROD_W  = G_W + MAG_W;
   localparam int LO_W    = 21;
   localparam int HI_W    = SQ_W - LO_W;
   localparam int DEN_W   = SQ_W + ROOT_W;
   localparam int QUO_BITS = OUT_W + 1;

   localparam logic [G_W-1:0] G_RESET = 24'h01_0000;

   // Cycles from the accepting edge to the edge that takes the result
   localparam int PIPE_LAT = 3 + (ROOT_W + 2) + 2 + (QUO_BITS + 2) + 1;

   typedef struct packed {
      logic [POS_W-1:0]  first_x;
      logic [POS_W-1:0]  first_y;
      logic [POS_W-1:0]  second_x;
      logic [POS_W-1:0]  second_y;
      logic [CELL_W-1:0] first_cell;
      logic [CELL_W-1:0] second_cell;
   } pgf_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] delta_ax;
      logic signed [OUT_W-1:0] delta_ay;
      logic                    applied;
      logic                    saturated;
   } pgf_rsp_type;

   // Sideband that rides along with an item through the root stages
   typedef struct packed {
      logic              applied;
      logic              neg_x;
      logic              neg_y;
      logic [PROD_W-1:0] num_x;
      logic [PROD_W-1:0] num_y;
   } pgf_ctl_type;

endpackage

>>> rtl/pgf_sqrt.sv
// Pipelined integer square root, rounded to nearest, one result bit per stage.
// Depends on pgf_pkg for widths.
module pgf_sqrt import pgf_pkg::*; #(
   parameter int TAG_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  logic [SQ_W-1:0]   in_s,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_vld,
   output logic [ROOT_W-1:0] out_root,
   output logic [SQ_W-1:0]   out_s,
   output logic [TAG_W-1:0]  out_tag
);

   localparam int RES_W = SQ_W + 1;

   logic              vld_ff [0:ROOT_W];
   logic [RES_W-1:0]  res_ff [0:ROOT_W];
   logic [SQ_W-1:0]   rem_ff [0:ROOT_W];
   logic [SQ_W-1:0]   s_ff   [0:ROOT_W];
   logic [TAG_W-1:0]  tag_ff [0:ROOT_W];

   logic              out_vld_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [SQ_W-1:0]   out_s_ff;
   logic [TAG_W-1:0]  out_tag_ff;
   logic [ROOT_W-1:0] root_in;

   // Load the remainder with the operand
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
      end
      res_ff[0] <= '0;
      rem_ff[0] <= in_s;
      s_ff[0]   <= in_s;
      tag_ff[0] <= in_tag;
   end

   // One root bit per stage, most significant first
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int SH = 2 * (ROOT_W - 1 - k);
      localparam logic [RES_W-1:0] BIT_C = RES_W'(1) << SH;
      logic [RES_W-1:0] trial;
      logic             ge;
      logic [RES_W-1:0] res_in;
      logic [SQ_W-1:0]  rem_in;

      always_comb begin
         trial  = res_ff[k] + BIT_C;
         ge     = RES_W'(rem_ff[k]) >= trial;
         res_in = ge ? ((res_ff[k] >> 1) + BIT_C) : (res_ff[k] >> 1);
         rem_in = ge ? SQ_W'(RES_W'(rem_ff[k]) - trial) : rem_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         res_ff[k+1] <= res_in;
         rem_ff[k+1] <= rem_in;
         s_ff[k+1]   <= s_ff[k];
         tag_ff[k+1] <= tag_ff[k];
      end
   end

   // Round up when the leftover exceeds the truncated root
   assign root_in = res_ff[ROOT_W][ROOT_W-1:0]
                  + ROOT_W'(RES_W'(rem_ff[ROOT_W]) > res_ff[ROOT_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[ROOT_W];
      end
      root_ff    <= root_in;
      out_s_ff   <= s_ff[ROOT_W];
      out_tag_ff <= tag_ff[ROOT_W];
   end

   assign out_vld  = out_vld_ff;
   assign out_root = root_ff;
   assign out_s    = out_s_ff;
   assign out_tag  = out_tag_ff;

endmodule

>>> rtl/pgf_div.sv
// Pipelined restoring divider: min(floor(num * 2^SHIFT / den), 2^32).
// One quotient bit per stage; depends on pgf_pkg for widths.
module pgf_div import pgf_pkg::*; #(
   parameter int SHIFT = 2 * PGF_POS_FRAC_BITS,
   parameter int TAG_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  logic [PROD_W-1:0]   in_num,
   input  logic [DEN_W-1:0]    in_den,
   input  logic [TAG_W-1:0]    in_tag,
   output logic                out_vld,
   output logic [QUO_BITS-1:0] out_quo,
   output logic [TAG_W-1:0]    out_tag
);

   localparam int DVD_W = PROD_W + SHIFT;
   localparam int CW    = (DVD_W > DEN_W) ? DVD_W : DEN_W;
   localparam logic [QUO_BITS-1:0] Q_MAX = QUO_BITS'(1) << OUT_W;

   logic [DVD_W-1:0] dvd;
   logic [DVD_W-1:0] top;
   logic             ovf_in;

   logic                vld_ff [0:QUO_BITS];
   logic                ovf_ff [0:QUO_BITS];
   logic [DEN_W-1:0]    rem_ff [0:QUO_BITS];
   logic [DEN_W-1:0]    den_ff [0:QUO_BITS];
   logic [QUO_BITS-1:0] lo_ff  [0:QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [0:QUO_BITS];
   logic [TAG_W-1:0]    tag_ff [0:QUO_BITS];

   logic                out_vld_ff;
   logic [QUO_BITS-1:0] out_quo_ff;
   logic [TAG_W-1:0]    out_tag_ff;
   logic [QUO_BITS-1:0] quo_in;

   // Flag quotients of 2^33 and above, start the remainder from the top bits
   always_comb begin
      dvd    = DVD_W'(in_num) << SHIFT;
      top    = dvd >> QUO_BITS;
      ovf_in = CW'(top) >= CW'(in_den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
      end
      ovf_ff[0] <= ovf_in;
      rem_ff[0] <= ovf_in ? '0 : DEN_W'(top);
      den_ff[0] <= in_den;
      lo_ff[0]  <= dvd[QUO_BITS-1:0];
      quo_ff[0] <= '0;
      tag_ff[0] <= in_tag;
   end

   // One quotient bit per stage, most significant first
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
      localparam int B = QUO_BITS - 1 - k;
      logic [DEN_W:0]   wide;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      logic [DEN_W:0]   diff;

      always_comb begin
         wide   = {rem_ff[k], lo_ff[k][B]};
         diff   = wide - {1'b0, den_ff[k]};
         ge     = wide >= {1'b0, den_ff[k]};
         rem_in = ge ? diff[DEN_W-1:0] : wide[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         ovf_ff[k+1] <= ovf_ff[k];
         rem_ff[k+1] <= rem_in;
         den_ff[k+1] <= den_ff[k];
         lo_ff[k+1]  <= lo_ff[k];
         quo_ff[k+1] <= quo_ff[k] | (QUO_BITS'(ge) << B);
         tag_ff[k+1] <= tag_ff[k];
      end
   end

   // Clamp the quotient at 2^32
   assign quo_in = (ovf_ff[QUO_BITS] || quo_ff[QUO_BITS] > Q_MAX) ? Q_MAX : quo_ff[QUO_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[QUO_BITS];
      end
      out_quo_ff <= quo_in;
      out_tag_ff <= tag_ff[QUO_BITS];
   end

   assign out_vld = out_vld_ff;
   assign out_quo = out_quo_ff;
   assign out_tag = out_tag_ff;

endmodule

>>> rtl/pair_gravity_force.sv
// Top level of the pair gravity force unit: difference, squares, root,
// denominator product and two dividers. Depends on pgf_pkg, pgf_sqrt, pgf_div.
//
// Usage:
//   Drive req_data with one particle pair and raise start; the item is taken
//   at each rising edge with start high and busy low. busy stays low, so a
//   new pair can enter every cycle and throughput is one item per cycle.
//   Each item gives one result on rsp_data, marked by rsp_strobe for exactly
//   one cycle. The result path runs through the 21-stage square root and the
//   33-stage dividers, one bit each.
//   Results leave in the order items entered. The receiver cannot hold off
//   results: the pipeline never stalls.
//   csr_we with csr_wdata loads the constant G (unsigned Q8.16); write it
//   only while no item is in flight.
//   Synchronous reset clears all valid bits, so nothing in flight survives,
//   and loads G with 1.0.
module pair_gravity_force import pgf_pkg::*; #(
   parameter int POS_FRAC_BITS = PGF_POS_FRAC_BITS,
   parameter int CELL_BITS     = PGF_CELL_BITS
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  pgf_req_type    req_data,
   output logic           rsp_strobe,
   output pgf_rsp_type    rsp_data,
   input  logic           csr_we,
   input  logic [G_W-1:0] csr_wdata
);

   localparam int CMP_W = (CELL_BITS < CELL_W) ? CELL_BITS : CELL_W;
   localparam int SHIFT = 2 * POS_FRAC_BITS;
   localparam logic [QUO_BITS-1:0] POS_LIM = QUO_BITS'(33'h0_7FFF_FFFF);
   localparam logic [QUO_BITS-1:0] NEG_LIM = QUO_BITS'(33'h0_8000_0000);

   logic [G_W-1:0] grav_ff;
   logic           accept;

   // Stage A: differences and cell match
   logic                  a_vld_ff, a_match_ff;
   logic signed [POS_W:0] a_dx_ff, a_dy_ff;
   logic signed [POS_W:0] a_dx_in, a_dy_in;

   // Stage B: magnitudes, squares, G products
   logic              b_vld_ff, b_match_ff, b_neg_x_ff, b_neg_y_ff;
   logic [SQR_W-1:0]  b_sqx_ff, b_sqy_ff;
   logic [PROD_W-1:0] b_num_x_ff, b_num_y_ff;
   logic [POS_W:0]    mag_x_w, mag_y_w;

   // Stage C: squared distance
   logic              c_vld_ff;
   logic [SQ_W-1:0]   c_s_ff;
   pgf_ctl_type       c_ctl_ff;
   logic [SQ_W-1:0]   s_in;

   // Root outputs
   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;
   logic [SQ_W-1:0]   sq_s;
   logic [$bits(pgf_ctl_type)-1:0] sq_tag;
   pgf_ctl_type       sq_ctl;

   // Denominator product stages
   logic              p1_vld_ff, p2_vld_ff;
   logic [HI_W+ROOT_W-1:0] p1_hi_ff;
   logic [LO_W+ROOT_W-1:0] p1_lo_ff;
   pgf_ctl_type       p1_ctl_ff, p2_ctl_ff;
   logic [DEN_W-1:0]  p2_den_ff;

   // Divider outputs
   logic                dx_vld, dy_vld;
   logic [QUO_BITS-1:0] qx, qy;
   logic [1:0]          dx_tag;
   logic                dy_tag;

   // Output register
   logic        rsp_strobe_ff;
   pgf_rsp_type rsp_ff;
   pgf_rsp_type rsp_in;
   logic        clip_x, clip_y;
   logic [OUT_W-1:0] ax_w, ay_w;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Hold the gravity constant
   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= G_RESET;
      end else if (csr_we) begin
         grav_ff <= csr_wdata;
      end
   end

   // Stage A
   always_comb begin
      a_dx_in = $signed({1'b0, req_data.first_x}) - $signed({1'b0, req_data.second_x});
      a_dy_in = $signed({1'b0, req_data.first_y}) - $signed({1'b0, req_data.second_y});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept;
      end
      a_dx_ff    <= a_dx_in;
      a_dy_ff    <= a_dy_in;
      a_match_ff <= req_data.first_cell[CMP_W-1:0] == req_data.second_cell[CMP_W-1:0];
   end

   // Stage B
   always_comb begin
      mag_x_w = a_dx_ff[POS_W] ? (POS_W+1)'(0) - a_dx_ff : a_dx_ff;
      mag_y_w = a_dy_ff[POS_W] ? (POS_W+1)'(0) - a_dy_ff : a_dy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
      b_match_ff <= a_match_ff;
      b_neg_x_ff <= a_dx_ff[POS_W];
      b_neg_y_ff <= a_dy_ff[POS_W];
      b_sqx_ff   <= mag_x_w[MAG_W-1:0] * mag_x_w[MAG_W-1:0];
      b_sqy_ff   <= mag_y_w[MAG_W-1:0] * mag_y_w[MAG_W-1:0];
      b_num_x_ff <= PROD_W'(grav_ff) * PROD_W'(mag_x_w[MAG_W-1:0]);
      b_num_y_ff <= PROD_W'(grav_ff) * PROD_W'(mag_y_w[MAG_W-1:0]);
   end

   // Stage C
   assign s_in = {1'b0, b_sqx_ff} + {1'b0, b_sqy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
      c_s_ff           <= s_in;
      c_ctl_ff.applied <= b_match_ff && (s_in != '0);
      c_ctl_ff.neg_x   <= b_neg_x_ff;
      c_ctl_ff.neg_y   <= b_neg_y_ff;
      c_ctl_ff.num_x   <= b_num_x_ff;
      c_ctl_ff.num_y   <= b_num_y_ff;
   end

   pgf_sqrt #(
      .TAG_W ($bits(pgf_ctl_type))
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (c_vld_ff),
      .in_s     (c_s_ff),
      .in_tag   (c_ctl_ff),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_s    (sq_s),
      .out_tag  (sq_tag)
   );

   assign sq_ctl = pgf_ctl_type'(sq_tag);

   // Split S * r into two partial products, then sum
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= sq_vld;
         p2_vld_ff <= p1_vld_ff;
      end
      p1_hi_ff  <= sq_s[SQ_W-1:LO_W] * sq_root;
      p1_lo_ff  <= sq_s[LO_W-1:0] * sq_root;
      p1_ctl_ff <= sq_ctl;
      p2_den_ff <= DEN_W'({p1_hi_ff, LO_W'(0)}) + DEN_W'(p1_lo_ff);
      p2_ctl_ff <= p1_ctl_ff;
   end

   pgf_div #(
      .SHIFT (SHIFT),
      .TAG_W (2)
   ) u_div_x (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (p2_vld_ff),
      .in_num  (p2_ctl_ff.num_x),
      .in_den  (p2_den_ff),
      .in_tag  ({p2_ctl_ff.applied, p2_ctl_ff.neg_x}),
      .out_vld (dx_vld),
      .out_quo (qx),
      .out_tag (dx_tag)
   );

   pgf_div #(
      .SHIFT (SHIFT),
      .TAG_W (1)
   ) u_div_y (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (p2_vld_ff),
      .in_num  (p2_ctl_ff.num_y),
      .in_den  (p2_den_ff),
      .in_tag  (p2_ctl_ff.neg_y),
      .out_vld (dy_vld),
      .out_quo (qy),
      .out_tag (dy_tag)
   );

   // Apply sign and clip each axis; drop everything for unapplied pairs
   always_comb begin
      if (dx_tag[0]) begin
         clip_x = qx > NEG_LIM;
         ax_w   = clip_x ? 32'h8000_0000 : OUT_W'(0) - qx[OUT_W-1:0];
      end else begin
         clip_x = qx > POS_LIM;
         ax_w   = clip_x ? 32'h7FFF_FFFF : qx[OUT_W-1:0];
      end
      if (dy_tag) begin
         clip_y = qy > NEG_LIM;
         ay_w   = clip_y ? 32'h8000_0000 : OUT_W'(0) - qy[OUT_W-1:0];
      end else begin
         clip_y = qy > POS_LIM;
         ay_w   = clip_y ? 32'h7FFF_FFFF : qy[OUT_W-1:0];
      end
      rsp_in.applied   = dx_tag[1];
      rsp_in.delta_ax  = dx_tag[1] ? $signed(ax_w) : '0;
      rsp_in.delta_ay  = dx_tag[1] ? $signed(ay_w) : '0;
      rsp_in.saturated = dx_tag[1] && (clip_x || clip_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dx_vld && dy_vld;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> rtl/pgf_checker.sv
// Port-level checks for pair_gravity_force, bound to the top level.
// Depends on pgf_pkg and pair_gravity_force.
module pgf_props import pgf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input pgf_rsp_type rsp_data
);

   // Every result traces back to an item taken a fixed time earlier
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_LAT))
      else $error("result without a matching item");

   // Every item gives its result after the fixed latency
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LAT rsp_strobe)
      else $error("item lost in pipeline");

   // Unapplied results carry zero deltas and no clip flag
   a_zero_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.applied) |->
      (rsp_data.delta_ax == '0 && rsp_data.delta_ay == '0 && !rsp_data.saturated))
      else $error("unapplied result not zero");

   // A clip shows a limit value on at least one axis
   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.saturated) |->
      (rsp_data.delta_ax == 32'sh7FFF_FFFF || rsp_data.delta_ax == 32'sh8000_0000 ||
       rsp_data.delta_ay == 32'sh7FFF_FFFF || rsp_data.delta_ay == 32'sh8000_0000))
      else $error("saturated without a limit value");

endmodule

bind pair_gravity_force pgf_props u_pgf_props (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

>>> verif/pgf_checker.sv
// Scoreboard for pair_gravity_force: follows the G register, predicts each result
// from the accepted item and compares it with the block's output. Depends on pgf_pkg.
`timescale 1ns / 1ps
module pgf_checker import pgf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           busy,
   input  pgf_req_type    req_data,
   input  logic           rsp_strobe,
   input  pgf_rsp_type    rsp_data,
   input  logic           csr_we,
   input  logic [G_W-1:0] csr_wdata,
   output int             fail_count,
   output int             pending_count,
   output int             result_count
);

   logic [G_W-1:0] grav_const;
   pgf_rsp_type    force_queue[$];

   // Integer square root, rounded to nearest
   function automatic logic [63:0] round_root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = 0;
      for (int b = 22; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      if (v - r * r > r) r = r + 1;
      return r;
   endfunction

   // Signed Q16.16 delta for one axis; sets clip when the value is limited
   function automatic logic [31:0] axis_force(logic signed [63:0] d, logic [63:0] den,
                                              inout logic clip);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (d < 0) ? 64'(-d) : 64'(d);
      q = ((64'(grav_const) * mag) << (2 * PGF_POS_FRAC_BITS)) / den;
      if (d >= 0) begin
         if (q > 64'h7FFF_FFFF) begin
            clip = 1'b1;
            return 32'h7FFF_FFFF;
         end
         return q[31:0];
      end
      if (q > 64'h8000_0000) begin
         clip = 1'b1;
         return 32'h8000_0000;
      end
      return 32'(0) - q[31:0];
   endfunction

   function automatic pgf_rsp_type predict_force(pgf_req_type p);
      pgf_rsp_type       r;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic [63:0]        s;
      logic [63:0]        den;
      logic               clip;
      r = '0;
      clip = 1'b0;
      dx = $signed({44'd0, p.first_x}) - $signed({44'd0, p.second_x});
      dy = $signed({44'd0, p.first_y}) - $signed({44'd0, p.second_y});
      if (p.first_cell[PGF_CELL_BITS-1:0] != p.second_cell[PGF_CELL_BITS-1:0]) return r;
      s = 64'(dx * dx) + 64'(dy * dy);
      if (s == 0) return r;
      den = s * round_root(s);
      r.delta_ax = axis_force(dx, den, clip);
      r.delta_ay = axis_force(dy, den, clip);
      r.applied = 1'b1;
      r.saturated = clip;
      return r;
   endfunction

   assign pending_count = force_queue.size();

   // Track G, queue predictions, compare results
   always @(posedge clock) begin
      pgf_rsp_type want;
      if (reset) begin
         grav_const <= G_RESET;
         force_queue.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (csr_we) grav_const <= csr_wdata;
         if (start && !busy) force_queue.push_back(predict_force(req_data));
         if (rsp_strobe) begin
            result_count <= result_count + 1;
            if (force_queue.size() == 0) begin
               $error("unexpected result");
               fail_count <= fail_count + 1;
            end else begin
               want = force_queue.pop_front();
               if (rsp_data !== want) begin
                  fail_count <= fail_count + 1;
                  if (rsp_data.delta_ax !== want.delta_ax)
                     $error("delta_ax exp %0d got %0d", want.delta_ax, rsp_data.delta_ax);
                  if (rsp_data.delta_ay !== want.delta_ay)
                     $error("delta_ay exp %0d got %0d", want.delta_ay, rsp_data.delta_ay);
                  if (rsp_data.applied !== want.applied)
                     $error("applied exp %0b got %0b", want.applied, rsp_data.applied);
                  if (rsp_data.saturated !== want.saturated)
                     $error("saturated exp %0b got %0b", want.saturated, rsp_data.saturated);
               end
            end
         end
      end
   end

endmodule

>>> verif/tb.sv
// Testbench top for pair_gravity_force: drives directed and random particle pairs across
// several G settings and idle patterns. Depends on pgf_pkg, pair_gravity_force, pgf_checker.
`timescale 1ns / 1ps
module tb import pgf_pkg::*; ();

   localparam int WATCH_LIMIT = 4 * PIPE_LAT + 400;

   logic           clock;
   logic           reset;
   logic           start;
   logic           busy;
   pgf_req_type    req_data;
   logic           rsp_strobe;
   pgf_rsp_type    rsp_data;
   logic           csr_we;
   logic [G_W-1:0] csr_wdata;
   int             fail_count;
   int             pending_count;
   int             result_count;
   int             idle_pct;
   int             quiet_cycles;
   int             item_total;

   pair_gravity_force u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   pgf_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_wdata(csr_wdata), .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCH_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Offer one item, idling first at random; hold until accepted
   task automatic send_pair(pgf_req_type p);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= p;
      @(posedge clock iff !busy);
      item_total++;
   endtask

   task automatic send_idle_end();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Drain the pipeline, then load G
   task automatic load_gravity(logic [G_W-1:0] g);
      send_idle_end();
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= g;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic pgf_req_type make_pair(logic [POS_W-1:0] x1, logic [POS_W-1:0] y1,
                                             logic [POS_W-1:0] x2, logic [POS_W-1:0] y2,
                                             logic [CELL_W-1:0] c1, logic [CELL_W-1:0] c2);
      pgf_req_type p;
      p.first_x = x1; p.first_y = y1; p.second_x = x2; p.second_y = y2;
      p.first_cell = c1; p.second_cell = c2;
      return p;
   endfunction

   // Mostly same-cell pairs at assorted distances, some noise
   function automatic pgf_req_type random_pair();
      pgf_req_type p;
      int span;
      int kind;
      p = '0;
      p.first_x = POS_W'($urandom); p.first_y = POS_W'($urandom);
      p.first_cell = CELL_W'($urandom);
      kind = $urandom_range(99);
      span = (kind < 30) ? 16 : (kind < 60) ? 1024 : (kind < 80) ? 65536 : 1048576;
      p.second_x = p.first_x + POS_W'($urandom_range(2 * span - 1)) - POS_W'(span);
      p.second_y = p.first_y + POS_W'($urandom_range(2 * span - 1)) - POS_W'(span);
      if (kind >= 95) begin
         p.second_x = p.first_x;
         p.second_y = p.first_y;
      end
      p.second_cell = ($urandom_range(99) < 80) ? p.first_cell : CELL_W'($urandom);
      return p;
   endfunction

   task automatic directed_pairs();
      send_pair(make_pair('0, '0, '1, '1, 16'h0000, 16'h0000));
      send_pair(make_pair('1, '1, '0, '0, 16'hFFFF, 16'hFFFF));
      send_pair(make_pair('1, '0, '0, '1, 16'hA5A5, 16'hA5A5));
      send_pair(make_pair(20'd100, 20'd100, 20'd100, 20'd100, 16'h0003, 16'h0003));
      send_pair(make_pair(20'd100, 20'd200, 20'd300, 20'd400, 16'h0001, 16'h0002));
      send_pair(make_pair(20'd100, 20'd200, 20'd300, 20'd400, 16'h8000, 16'h0000));
      send_pair(make_pair(20'd1, 20'd0, 20'd0, 20'd0, 16'h0007, 16'h0007));
      send_pair(make_pair(20'd0, 20'd0, 20'd1, 20'd0, 16'h0007, 16'h0007));
      send_pair(make_pair(20'd0, 20'd1, 20'd0, 20'd0, 16'h0007, 16'h0007));
      send_pair(make_pair(20'd0, 20'd0, 20'd0, 20'd1, 16'h0007, 16'h0007));
      send_pair(make_pair(20'd3, 20'd4, 20'd0, 20'd0, 16'h1234, 16'h1234));
      send_pair(make_pair(20'd256, 20'd0, 20'd0, 20'd256, 16'h1234, 16'h1234));
      send_pair(make_pair(20'hFFFFF, 20'd5, 20'hFFFFE, 20'd5, 16'hFFFF, 16'hFFFF));
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      idle_pct = 0;
      quiet_cycles = 0;
      item_total = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset value of G, then the register extremes and the value 1, then random settings
      directed_pairs();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: ;
            1: load_gravity('0);
            2: load_gravity('1);
            3: load_gravity(24'd1);
            default: load_gravity(G_W'($urandom));
         endcase
         if (phase == 1 || phase == 2) directed_pairs();
         for (int n = 0; n < 270; n++) begin
            idle_pct = (n < 90) ? 0 : (n < 180) ? 47 : 12;
            send_pair(random_pair());
         end
         idle_pct = 0;
      end

      send_idle_end();
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
      $display("Sent %0d particle pairs over six G settings, %0d forces checked.",
               item_total, result_count);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
